@@ rtl/fosm_pkg.sv @@
// ----------------------------------------------------------------------------
// fosm_pkg: shared types and constants of the frame overrun and stats monitor
// Field widths, opcodes, register indexes and the structs passed between the
// window, statistics and averaging units.
// ----------------------------------------------------------------------------
package fosm_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 256;

  // Statistics period; a power of two so that averages are plain shifts.
  localparam int unsigned STATS_PERIOD = 256;
  localparam int unsigned STATS_SHIFT  = $clog2(STATS_PERIOD);
  localparam int unsigned PERIOD_W     = $clog2(STATS_PERIOD + 1);

  localparam int unsigned TIME_W = 40;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned LINE_W = 10;
  localparam int unsigned LSUM_W = 18;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [LINE_W-1:0] LINE_MAX  = '1;
  localparam logic [LSUM_W-1:0] LSUM_MAX  = '1;
  localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;

  typedef enum logic [1:0] {
    OP_FRAME_END   = 2'd0,
    OP_ADD_RENDER  = 2'd1,
    OP_ADD_PRESENT = 2'd2,
    OP_CLEAR_WARN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SLOW_HOST = 2'd0,
    CFG_STATS_EN  = 2'd1,
    CFG_TURBO     = 2'd2
  } cfg_e;

  typedef struct packed {
    logic xfer;
    logic frame_ok;
    op_e  op;
    logic over;
    logic slow_host_en;
    logic turbo;
  } win_ctrl_t;

  typedef struct packed {
    logic xfer;
    logic frame_ok;
    op_e  op;
    logic on_time;
    logic stats_en;
  } st_ctrl_t;

  typedef struct packed {
    logic                          stats_valid;
    logic [SUM_W-1:0]              frame;
    logic [SUM_W-1:0]              idle;
    logic [SUM_W-1:0]              render;
    logic [SUM_W-1:0]              present;
    logic [2:0][LSUM_W-1:0]        lines;
    logic [PERIOD_W-1:0]           late;
  } snap_t;

  typedef struct packed {
    logic s3_load;
    logic s4_load;
  } avg_ctrl_t;

  typedef struct packed {
    logic                   warning;
    logic                   stats_valid;
    logic [TIME_W-1:0]      frame;
    logic [TIME_W-1:0]      idle;
    logic [TIME_W-1:0]      render;
    logic [TIME_W-1:0]      present;
    logic [TIME_W-1:0]      emu;
    logic [PCT_W-1:0]       late_pct;
    logic [2:0][LINE_W-1:0] lines;
  } res_t;

endpackage

@@ rtl/fosm_cell.sv @@
// ----------------------------------------------------------------------------
// fosm_cell: one entry of the overrun window
// Holds one overrun bit and takes its neighbor's bit on each shift.
// ----------------------------------------------------------------------------
module fosm_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic d_i,
  output logic q_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= d_i;
    end
  end

  assign q_o = bit_q;

endmodule

@@ rtl/fosm_window.sv @@
// ----------------------------------------------------------------------------
// fosm_window: sliding overrun window and slow host warning
// A chain of one-bit cells; the bit leaving the far end is the oldest entry.
// ----------------------------------------------------------------------------
module fosm_window #(
  parameter int unsigned WINDOW_DEPTH = fosm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fosm_pkg::win_ctrl_t                  ctrl_i,
  output logic                                 warning_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]    overrun_o
);

  localparam int unsigned POS_W   = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TRIGGER = (WINDOW_DEPTH * 3) / 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_DEPTH - 1);

  logic [WINDOW_DEPTH-1:0] tap;
  logic                    record;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] sum_q, sum_d;
  logic             full_q, full_d;
  logic             warn_q, warn_d;
  logic             fired_q, fired_d;

  assign record = ctrl_i.xfer && (ctrl_i.op == fosm_pkg::OP_FRAME_END) && ctrl_i.frame_ok
                  && ctrl_i.slow_host_en && !ctrl_i.turbo && !fired_q;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      fosm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (record),
        .d_i     (ctrl_i.over),
        .q_o     (tap[i])
      );
    end else begin : g_body
      fosm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (record),
        .d_i     (tap[i-1]),
        .q_o     (tap[i])
      );
    end
  end

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    full_d  = full_q;
    warn_d  = warn_q;
    fired_d = fired_q;
    if (record) begin
      // drop the oldest entry, add the new one
      sum_d = sum_q - CNT_W'(tap[WINDOW_DEPTH-1]) + CNT_W'(ctrl_i.over);
      if (pos_q == LAST_POS) begin
        pos_d  = '0;
        full_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      if (full_d && (sum_d >= CNT_W'(TRIGGER))) begin
        warn_d  = 1'b1;
        fired_d = 1'b1;
      end
    end else if (ctrl_i.xfer && (ctrl_i.op == fosm_pkg::OP_CLEAR_WARN)) begin
      warn_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      full_q  <= 1'b0;
      warn_q  <= 1'b0;
      fired_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      full_q  <= full_d;
      warn_q  <= warn_d;
      fired_q <= fired_d;
    end
  end

  assign warning_o = warn_q;
  assign overrun_o = sum_q;

endmodule

@@ rtl/fosm_stats.sv @@
// ----------------------------------------------------------------------------
// fosm_stats: period accumulators
// Saturating time and line sums and a late-frame count; snapshot them when a period closes.
// ----------------------------------------------------------------------------
module fosm_stats (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  fosm_pkg::st_ctrl_t                           ctrl_i,
  input  logic [fosm_pkg::TIME_W-1:0]                  frame_i,
  input  logic [fosm_pkg::TIME_W-1:0]                  idle_i,
  input  logic [fosm_pkg::TIME_W-1:0]                  added_i,
  input  logic [2:0][fosm_pkg::LINE_W-1:0]             lines_i,
  output fosm_pkg::snap_t                              snap_o
);

  function automatic logic [fosm_pkg::SUM_W-1:0] sat_time(
    input logic [fosm_pkg::SUM_W-1:0]  sum,
    input logic [fosm_pkg::TIME_W-1:0] add
  );
    logic [fosm_pkg::SUM_W:0] s;
    s = {1'b0, sum} + (fosm_pkg::SUM_W + 1)'(add);
    return s[fosm_pkg::SUM_W] ? fosm_pkg::SUM_MAX : s[fosm_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [fosm_pkg::LSUM_W-1:0] sat_line(
    input logic [fosm_pkg::LSUM_W-1:0] sum,
    input logic [fosm_pkg::LINE_W-1:0] add
  );
    logic [fosm_pkg::LSUM_W:0] s;
    s = {1'b0, sum} + (fosm_pkg::LSUM_W + 1)'(add);
    return s[fosm_pkg::LSUM_W] ? fosm_pkg::LSUM_MAX : s[fosm_pkg::LSUM_W-1:0];
  endfunction

  logic [fosm_pkg::PERIOD_W-1:0]      frames_q, frames_d, frames_nxt;
  logic [fosm_pkg::SUM_W-1:0]         frame_q, frame_d, frame_nxt;
  logic [fosm_pkg::SUM_W-1:0]         idle_q, idle_d, idle_nxt;
  logic [fosm_pkg::SUM_W-1:0]         render_q, render_d;
  logic [fosm_pkg::SUM_W-1:0]         present_q, present_d;
  logic [2:0][fosm_pkg::LSUM_W-1:0]   lines_q, lines_d, lines_nxt;
  logic [fosm_pkg::PERIOD_W-1:0]      late_q, late_d, late_nxt;
  logic                               frame_ev, done;
  fosm_pkg::snap_t                    snap_q, snap_d;
  logic                               valid_q, valid_d;

  assign frame_ev = ctrl_i.xfer && (ctrl_i.op == fosm_pkg::OP_FRAME_END)
                    && ctrl_i.frame_ok && ctrl_i.stats_en;

  always_comb begin
    frames_nxt = frames_q + 1'b1;
    frame_nxt  = sat_time(frame_q, frame_i);
    idle_nxt   = sat_time(idle_q, idle_i);
    for (int i = 0; i < 3; i++) begin
      lines_nxt[i] = sat_line(lines_q[i], lines_i[i]);
    end
    late_nxt = late_q + fosm_pkg::PERIOD_W'(!ctrl_i.on_time);
    done     = frames_nxt >= fosm_pkg::PERIOD_W'(fosm_pkg::STATS_PERIOD);

    frames_d  = frames_q;
    frame_d   = frame_q;
    idle_d    = idle_q;
    render_d  = render_q;
    present_d = present_q;
    lines_d   = lines_q;
    late_d    = late_q;
    snap_d    = snap_q;
    valid_d   = valid_q;

    if (ctrl_i.xfer) begin
      valid_d = frame_ev && done;
    end
    if (ctrl_i.xfer && (ctrl_i.op == fosm_pkg::OP_ADD_RENDER)) begin
      render_d = sat_time(render_q, added_i);
    end
    if (ctrl_i.xfer && (ctrl_i.op == fosm_pkg::OP_ADD_PRESENT)) begin
      present_d = sat_time(present_q, added_i);
    end
    if (frame_ev) begin
      if (done) begin
        // close the period: capture the sums, then restart from zero
        snap_d.frame   = frame_nxt;
        snap_d.idle    = idle_nxt;
        snap_d.render  = render_q;
        snap_d.present = present_q;
        snap_d.lines   = lines_nxt;
        snap_d.late    = late_nxt;
        frames_d  = '0;
        frame_d   = '0;
        idle_d    = '0;
        render_d  = '0;
        present_d = '0;
        lines_d   = '0;
        late_d    = '0;
      end else begin
        frames_d = frames_nxt;
        frame_d  = frame_nxt;
        idle_d   = idle_nxt;
        lines_d  = lines_nxt;
        late_d   = late_nxt;
      end
    end
    snap_d.stats_valid = valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q  <= '0;
      frame_q   <= '0;
      idle_q    <= '0;
      render_q  <= '0;
      present_q <= '0;
      lines_q   <= '0;
      late_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      frames_q  <= frames_d;
      frame_q   <= frame_d;
      idle_q    <= idle_d;
      render_q  <= render_d;
      present_q <= present_d;
      lines_q   <= lines_d;
      late_q    <= late_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  always_comb begin
    snap_o             = snap_q;
    snap_o.stats_valid = valid_q;
  end

endmodule

@@ rtl/fosm_avg.sv @@
// ----------------------------------------------------------------------------
// fosm_avg: two-stage averaging pipe
// Shift and clamp the period sums, then form the emulation time average.
// ----------------------------------------------------------------------------
module fosm_avg #(
  parameter int unsigned WINDOW_DEPTH = fosm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  fosm_pkg::avg_ctrl_t                  ctrl_i,
  input  logic                                 warning_i,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]    overrun_i,
  input  fosm_pkg::snap_t                      snap_i,
  output fosm_pkg::res_t                       res_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]    overrun_o
);

  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SPENT_W = fosm_pkg::SUM_W + 2;
  localparam int unsigned PROD_W  = fosm_pkg::PERIOD_W + fosm_pkg::PCT_W;

  function automatic logic [fosm_pkg::TIME_W-1:0] avg_time(
    input logic [SPENT_W-1:0] sum
  );
    logic [SPENT_W-1:0] q;
    q = sum >> fosm_pkg::STATS_SHIFT;
    return (q > SPENT_W'(fosm_pkg::TIME_MAX)) ? fosm_pkg::TIME_MAX
                                              : q[fosm_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [fosm_pkg::LINE_W-1:0] avg_line(
    input logic [fosm_pkg::LSUM_W-1:0] sum
  );
    logic [fosm_pkg::LSUM_W-1:0] q;
    q = sum >> fosm_pkg::STATS_SHIFT;
    return (q > fosm_pkg::LSUM_W'(fosm_pkg::LINE_MAX)) ? fosm_pkg::LINE_MAX
                                                       : q[fosm_pkg::LINE_W-1:0];
  endfunction

  // stage 3
  fosm_pkg::res_t          s3_d, s3_q;
  logic [SPENT_W-1:0]      s3_frame_d, s3_frame_q;
  logic [SPENT_W-1:0]      s3_spent_d, s3_spent_q;
  logic [CNT_W-1:0]        s3_ovr_q;
  logic [PROD_W-1:0]       late_prod, late_div;

  // stage 4
  fosm_pkg::res_t          s4_d, s4_q;
  logic [SPENT_W-1:0]      emu_diff;
  logic [CNT_W-1:0]        s4_ovr_q;

  always_comb begin
    late_prod = PROD_W'(snap_i.late) * PROD_W'(fosm_pkg::PCT_SCALE);
    late_div  = late_prod >> fosm_pkg::STATS_SHIFT;
    s3_d             = '0;
    s3_d.warning     = warning_i;
    s3_d.stats_valid = snap_i.stats_valid;
    s3_frame_d       = '0;
    s3_spent_d       = '0;
    if (snap_i.stats_valid) begin
      s3_d.frame    = avg_time(SPENT_W'(snap_i.frame));
      s3_d.idle     = avg_time(SPENT_W'(snap_i.idle));
      s3_d.render   = avg_time(SPENT_W'(snap_i.render));
      s3_d.present  = avg_time(SPENT_W'(snap_i.present));
      s3_d.late_pct = (late_div > PROD_W'(fosm_pkg::PCT_SCALE)) ? fosm_pkg::PCT_SCALE
                                                               : late_div[fosm_pkg::PCT_W-1:0];
      for (int i = 0; i < 3; i++) begin
        s3_d.lines[i] = avg_line(snap_i.lines[i]);
      end
      s3_frame_d = SPENT_W'(snap_i.frame);
      s3_spent_d = SPENT_W'(snap_i.idle) + SPENT_W'(snap_i.render)
                   + SPENT_W'(snap_i.present);
    end
  end

  always_comb begin
    emu_diff = s3_frame_q - s3_spent_q;
    s4_d     = s3_q;
    // clamp at zero when idle, render and present eat the whole frame time
    s4_d.emu = (s3_frame_q > s3_spent_q) ? avg_time(emu_diff) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_load) begin
      s3_q       <= s3_d;
      s3_frame_q <= s3_frame_d;
      s3_spent_q <= s3_spent_d;
      s3_ovr_q   <= overrun_i;
    end
    if (ctrl_i.s4_load) begin
      s4_q     <= s4_d;
      s4_ovr_q <= s3_ovr_q;
    end
  end

  assign res_o     = s4_q;
  assign overrun_o = s4_ovr_q;

endmodule

@@ rtl/frame_overrun_and_stats_monitor.sv @@
// ----------------------------------------------------------------------------
// frame_overrun_and_stats_monitor: frame overrun window and period statistics
// Tracks frame overruns in a sliding window of one-bit cells, raises a sticky
// slow host warning once, and emits averaged statistics every period.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------------
//   in       | input     | in_valid_i / in_stall_o | opcode, frame data, added time
//   out      | output    | out_valid_o / out_stall_i | warning, overrun, averages
//   cfg      | input     | psel/penable/pwrite     | slow host, stats, turbo enables
//
// One word per cycle sustained while the output is not stalled; each word passes through every stage.
// The pipe is input register, state update (window cells and accumulators),
// average shift/clamp, emulation time subtract; the last stage is the output.
// Each stage advances when the next one is empty or moving, so a stall on the
// output fills bubbles before it reaches in_stall_o.
// Reset clears the window cells, counters and sums at once; no clearing pass.
// The window is WINDOW_DEPTH one-bit cells, shifted once per recorded frame.
// ----------------------------------------------------------------------------
module frame_overrun_and_stats_monitor #(
  parameter int unsigned WINDOW_DEPTH = fosm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fosm_pkg::ADDR_W-1:0]           paddr,
  input  logic [fosm_pkg::DATA_W-1:0]           pwdata,
  output logic [fosm_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,

  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            opcode_i,
  input  logic [fosm_pkg::TIME_W-1:0]           frame_time_ns_i,
  input  logic [fosm_pkg::TIME_W-1:0]           idle_time_ns_i,
  input  logic [fosm_pkg::TIME_W-1:0]           budget_ns_i,
  input  logic                                  frame_on_time_i,
  input  logic [fosm_pkg::LINE_W-1:0]           full_lines_i,
  input  logic [fosm_pkg::LINE_W-1:0]           fast_lines_i,
  input  logic [fosm_pkg::LINE_W-1:0]           skipped_lines_i,
  input  logic [fosm_pkg::TIME_W-1:0]           added_time_ns_i,

  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  warning_flag_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]     overrun_total_o,
  output logic                                  stats_valid_o,
  output logic [fosm_pkg::TIME_W-1:0]           avg_frame_ns_o,
  output logic [fosm_pkg::TIME_W-1:0]           avg_idle_ns_o,
  output logic [fosm_pkg::TIME_W-1:0]           avg_render_ns_o,
  output logic [fosm_pkg::TIME_W-1:0]           avg_present_ns_o,
  output logic [fosm_pkg::TIME_W-1:0]           avg_emu_ns_o,
  output logic [fosm_pkg::PCT_W-1:0]            late_percent_o,
  output logic [fosm_pkg::LINE_W-1:0]           avg_full_lines_o,
  output logic [fosm_pkg::LINE_W-1:0]           avg_fast_lines_o,
  output logic [fosm_pkg::LINE_W-1:0]           avg_skipped_lines_o
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned DIFF_W = fosm_pkg::TIME_W + 1;
  localparam int unsigned TEN_W  = fosm_pkg::TIME_W + 4;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic slow_q, stats_en_q, turbo_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q     <= 1'b1;
      stats_en_q <= 1'b0;
      turbo_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fosm_pkg::CFG_SLOW_HOST: slow_q     <= pwdata[0];
        fosm_pkg::CFG_STATS_EN:  stats_en_q <= pwdata[0];
        fosm_pkg::CFG_TURBO:     turbo_q    <= pwdata[0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fosm_pkg::CFG_SLOW_HOST: prdata = fosm_pkg::DATA_W'(slow_q);
      fosm_pkg::CFG_STATS_EN:  prdata = fosm_pkg::DATA_W'(stats_en_q);
      fosm_pkg::CFG_TURBO:     prdata = fosm_pkg::DATA_W'(turbo_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipe flow control: a stage takes a word when it is empty or moving on
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc, xfer12, xfer23, xfer34;

  assign rdy4   = !s4_v_q || !out_stall_i;
  assign rdy3   = !s3_v_q || rdy4;
  assign rdy2   = !s2_v_q || rdy3;
  assign rdy1   = !s1_v_q || rdy2;
  assign in_acc = in_valid_i && rdy1;
  assign xfer12 = s1_v_q && rdy2;
  assign xfer23 = s2_v_q && rdy3;
  assign xfer34 = s3_v_q && rdy4;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc || (s1_v_q && !rdy2);
      s2_v_q <= xfer12 || (s2_v_q && !rdy3);
      s3_v_q <= xfer23 || (s3_v_q && !rdy4);
      s4_v_q <= xfer34 || (s4_v_q && out_stall_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the word, precompute frame minus budget
  // --------------------------------------------------------------------------
  fosm_pkg::op_e                       op_q;
  logic                                frame_ok_q;
  logic [DIFF_W-1:0]                   diff_q;
  logic [fosm_pkg::TIME_W-1:0]         budget_q, frame_q, idle_q, added_q;
  logic [2:0][fosm_pkg::LINE_W-1:0]    lines_q;
  logic                                on_time_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= fosm_pkg::op_e'(opcode_i);
      frame_ok_q <= (frame_time_ns_i != '0) && (budget_ns_i != '0);
      diff_q     <= {1'b0, frame_time_ns_i} - {1'b0, budget_ns_i};
      budget_q   <= budget_ns_i;
      frame_q    <= frame_time_ns_i;
      idle_q     <= idle_time_ns_i;
      added_q    <= added_time_ns_i;
      lines_q    <= {skipped_lines_i, fast_lines_i, full_lines_i};
      on_time_q  <= frame_on_time_i;
    end
  end

  // frame > budget + budget/10  <=>  frame > budget and budget < 10*(frame-budget)
  logic [TEN_W-1:0] diff_x10;
  logic             over;

  assign diff_x10 = {1'b0, diff_q[fosm_pkg::TIME_W-1:0], 3'b000}
                  + {3'b000, diff_q[fosm_pkg::TIME_W-1:0], 1'b0};
  assign over     = !diff_q[DIFF_W-1] && (TEN_W'(budget_q) < diff_x10);

  // --------------------------------------------------------------------------
  // Stage 2: window cells and period accumulators update on entry
  // --------------------------------------------------------------------------
  fosm_pkg::win_ctrl_t win_ctrl;
  fosm_pkg::st_ctrl_t  st_ctrl;
  logic                warning;
  logic [CNT_W-1:0]    overrun;
  fosm_pkg::snap_t     snap;

  always_comb begin
    win_ctrl.xfer         = xfer12;
    win_ctrl.frame_ok     = frame_ok_q;
    win_ctrl.op           = op_q;
    win_ctrl.over         = over;
    win_ctrl.slow_host_en = slow_q;
    win_ctrl.turbo        = turbo_q;

    st_ctrl.xfer     = xfer12;
    st_ctrl.frame_ok = frame_ok_q;
    st_ctrl.op       = op_q;
    st_ctrl.on_time  = on_time_q;
    st_ctrl.stats_en = stats_en_q;
  end

  fosm_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .warning_o (warning),
    .overrun_o (overrun)
  );

  fosm_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (st_ctrl),
    .frame_i (frame_q),
    .idle_i  (idle_q),
    .added_i (added_q),
    .lines_i (lines_q),
    .snap_o  (snap)
  );

  // --------------------------------------------------------------------------
  // Stages 3 and 4: averages; stage 4 is the output register
  // --------------------------------------------------------------------------
  fosm_pkg::avg_ctrl_t avg_ctrl;
  fosm_pkg::res_t      res;

  assign avg_ctrl.s3_load = xfer23;
  assign avg_ctrl.s4_load = xfer34;

  fosm_avg #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_avg (
    .clk_i     (clk_i),
    .ctrl_i    (avg_ctrl),
    .warning_i (warning),
    .overrun_i (overrun),
    .snap_i    (snap),
    .res_o     (res),
    .overrun_o (overrun_total_o)
  );

  assign out_valid_o         = s4_v_q;
  assign warning_flag_o      = res.warning;
  assign stats_valid_o       = res.stats_valid;
  assign avg_frame_ns_o      = res.frame;
  assign avg_idle_ns_o       = res.idle;
  assign avg_render_ns_o     = res.render;
  assign avg_present_ns_o    = res.present;
  assign avg_emu_ns_o        = res.emu;
  assign late_percent_o      = res.late_pct;
  assign avg_full_lines_o    = res.lines[0];
  assign avg_fast_lines_o    = res.lines[1];
  assign avg_skipped_lines_o = res.lines[2];

endmodule
